FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the read responder.
// Each macro builds one clocked concurrent assertion on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that one condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/dirr_pkg.sv
// Package for the discrete input read responder: payload structs and codes.
// It has no dependencies and is imported by the top level.
`timescale 1ns / 1ps

package dirr_pkg;

  localparam logic [15:0] QTY_MAX = 16'h07D0;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [7:0] EXC_ADDR = 8'd2;
  localparam logic [7:0] EXC_VALUE = 8'd3;
  localparam logic [7:0] MIN_REQUEST_LENGTH = 8'd4;
  localparam logic [2:0] LAST_BIT_POSITION = 3'd7;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_BIT = 1'b1;

  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_EXCEPTION = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_REQ_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_RSP_TRUNC = 2'd2;

  localparam logic [1:0] CFG_FIRST_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_LAST_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam logic [15:0] FIRST_ADDRESS_RESET = 16'h0000;
  localparam logic [15:0] LAST_ADDRESS_RESET = 16'hFFFF;
  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  request_length;
    logic        input_bit;
  } dirr_in_t;

  typedef struct packed {
    logic [7:0] response_code;
    logic [7:0] data_byte;
    logic [1:0] byte_kind;
    logic [1:0] status;
    logic       last;
  } dirr_out_t;

endpackage

FILE: rtl/discrete_input_read_responder.sv
// Top level of the discrete input read responder: request checks and bit packing.
// Depends on dirr_pkg and on assert_macros.svh for its assertions.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  in_data (dirr_in_t)
//   out       output     out_valid / out_stall out_data (dirr_out_t)
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A new transfer is taken in every cycle while in_stall is low.
// An output register and a skid register hold up to two results, so a transfer
// is still taken while one result waits; in_stall rises only when both are full.
// Synchronous reset clears the flags and transfer state but not the data registers.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module discrete_input_read_responder
  import dirr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  dirr_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dirr_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] valid_first_address;
  logic [15:0] valid_last_address;
  logic [8:0]  response_capacity;

  logic        transfer_active, transfer_active_next;
  logic [10:0] bits_remaining, bits_remaining_next;
  logic [2:0]  bit_position, bit_position_next;
  logic [7:0]  packing_byte, packing_byte_next;
  logic [8:0]  bytes_written, bytes_written_next;
  logic [7:0]  saved_code, saved_code_next;

  logic        skid_valid;
  dirr_out_t   skid_data;

  logic        accept;
  logic        take;
  logic        res_valid;
  dirr_out_t   res;

  logic [16:0] end_address;
  logic        qty_bad;
  logic        addr_bad;
  logic        capacity_zero;
  logic [10:0] qty_minus_one;
  logic [7:0]  byte_count;
  logic [7:0]  packed_byte;
  logic [10:0] remaining_dec;
  logic        emit;
  logic        fin;

  assign cfg_ready = 1'b1;
  assign in_stall = skid_valid;
  assign accept = in_valid && !in_stall;
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_first_address <= FIRST_ADDRESS_RESET;
      valid_last_address <= LAST_ADDRESS_RESET;
      response_capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_ADDRESS: valid_first_address <= cfg_data;
        CFG_LAST_ADDRESS: valid_last_address <= cfg_data;
        CFG_CAPACITY: response_capacity <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign end_address = {1'b0, in_data.start_address} + {1'b0, in_data.quantity} - 17'd1;
  assign qty_bad = (in_data.quantity == 16'd0) || (in_data.quantity > QTY_MAX);
  assign addr_bad = (in_data.start_address < valid_first_address)
                 || (in_data.start_address > valid_last_address)
                 || end_address[16]
                 || (end_address[15:0] < valid_first_address)
                 || (end_address[15:0] > valid_last_address);
  assign capacity_zero = (response_capacity == 9'd0);
  assign qty_minus_one = in_data.quantity[10:0] - 11'd1;
  assign byte_count = qty_minus_one[10:3] + 8'd1;

  assign packed_byte = packing_byte | (8'(in_data.input_bit) << bit_position);
  assign remaining_dec = bits_remaining - 11'd1;
  assign emit = (bit_position == LAST_BIT_POSITION) || (remaining_dec == 11'd0);
  assign fin = (remaining_dec == 11'd0);

  always_comb begin
    transfer_active_next = transfer_active;
    bits_remaining_next = bits_remaining;
    bit_position_next = bit_position;
    packing_byte_next = packing_byte;
    bytes_written_next = bytes_written;
    saved_code_next = saved_code;
    res_valid = 1'b0;
    res = '0;
    if (in_data.cmd == CMD_HEADER) begin
      transfer_active_next = 1'b0;
      bits_remaining_next = '0;
      bit_position_next = '0;
      packing_byte_next = '0;
      bytes_written_next = '0;
      saved_code_next = '0;
      res_valid = 1'b1;
      res.last = 1'b1;
      if (in_data.request_length < MIN_REQUEST_LENGTH) begin
        res.status = STATUS_REQ_TRUNC;
      end else if (qty_bad || addr_bad) begin
        res.byte_kind = KIND_EXCEPTION;
        if (capacity_zero) begin
          res.status = STATUS_RSP_TRUNC;
        end else begin
          res.response_code = in_data.function_code + EXC_FLAG;
          res.data_byte = qty_bad ? EXC_VALUE : EXC_ADDR;
        end
      end else if (capacity_zero) begin
        res.status = STATUS_RSP_TRUNC;
      end else begin
        res.response_code = in_data.function_code;
        res.data_byte = byte_count;
        res.last = 1'b0;
        transfer_active_next = 1'b1;
        bits_remaining_next = in_data.quantity[10:0];
        bytes_written_next = 9'd1;
        saved_code_next = in_data.function_code;
      end
    end else if (transfer_active) begin
      bits_remaining_next = remaining_dec;
      if (!emit) begin
        bit_position_next = bit_position + 3'd1;
        packing_byte_next = packed_byte;
      end else begin
        res_valid = 1'b1;
        bit_position_next = '0;
        packing_byte_next = '0;
        if (bytes_written >= response_capacity) begin
          res.byte_kind = KIND_DATA;
          res.status = STATUS_RSP_TRUNC;
          res.last = 1'b1;
          transfer_active_next = 1'b0;
          bits_remaining_next = '0;
          bytes_written_next = '0;
          saved_code_next = '0;
        end else begin
          res.response_code = saved_code;
          res.data_byte = packed_byte;
          res.byte_kind = KIND_DATA;
          res.last = fin;
          bytes_written_next = bytes_written + 9'd1;
          if (fin) begin
            transfer_active_next = 1'b0;
            bytes_written_next = '0;
            saved_code_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_active <= 1'b0;
      bits_remaining <= '0;
      bit_position <= '0;
      packing_byte <= '0;
      bytes_written <= '0;
      saved_code <= '0;
    end else if (accept) begin
      transfer_active <= transfer_active_next;
      bits_remaining <= bits_remaining_next;
      bit_position <= bit_position_next;
      packing_byte <= packing_byte_next;
      bytes_written <= bytes_written_next;
      saved_code <= saved_code_next;
    end
  end

  // The skid register is only filled while the output register holds a waiting result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && res_valid) begin
        out_data <= res;
      end
    end else if (accept && res_valid) begin
      skid_data <= res;
    end
  end

  `ASSERT_CLK(a_skid_needs_out, !skid_valid || out_valid, "Skid register full while output register is empty.")
  `ASSERT_CLK(a_active_has_bits, !transfer_active || (bits_remaining != 11'd0), "Active transfer with no bits remaining.")
  `ASSERT_CLK(a_idle_is_clear, transfer_active || ((bit_position == 3'd0) && (packing_byte == 8'd0)), "Idle with a partly packed byte.")
  `ASSERT_NEXT(a_stalled_out_holds, out_valid && out_stall && !rst, out_valid && $stable(out_data), "Stalled result changed before its transfer.")

endmodule
